/* rtl/sem_pkg.sv */
// ---------------------------------------------------------------------------
// sem_pkg: shared constants for the Sobel edge magnitude block
// Widths, line store depth, register indexes and register reset values.
// ---------------------------------------------------------------------------
package sem_pkg;

   localparam int MAX_WIDTH = 2048;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int DIM_W     = 12;
   localparam int ROW_W     = 12;
   localparam int PIX_W     = 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;
   localparam logic [DIM_W-1:0] DIM_MIN      = 12'd3;
   localparam logic [DIM_W-1:0] WIDTH_MAX    = DIM_W'(MAX_WIDTH);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   typedef logic [PIX_W-1:0] pixel_type;

endpackage

/* rtl/sobel_edge_magnitude.sv */
// ---------------------------------------------------------------------------
// sobel_edge_magnitude: 3x3 Sobel edge detector, L1 magnitude
// Raster-order 8-bit pixels in, |gx|+|gy| saturated to 255 out for every
// interior pixel. Two line stores and a six-pixel window feed the filter.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+----------------------------------
//   req     | in  | req_tvalid/tready  | tdata[7:0] pixel
//   rsp     | out | rsp_tvalid/tready  | tdata[7:0] edge_magnitude,
//           |     |                    | tlast row_end, tuser[0] frame_end
//   csr     | in  | csr_valid/ready    | csr_index, csr_data[11:0]
//
// One pixel per clock sustained while the result side does not stall.
// Stage 1 holds the pixel and the registered line store reads, stage 2 is the
// result register. Border pixels leave stage 1 without producing a beat.
// A stalled result holds an interior pixel in stage 1, which drops req_tready
// that same cycle; a border pixel in stage 1 still advances.
// Reset clears counters, window and valid flags; line stores need no clearing.
// ---------------------------------------------------------------------------
module sobel_edge_magnitude
   import sem_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] pixel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [7:0] edge_magnitude
   output logic                 rsp_tlast,   // row_end
   output logic [0:0]           rsp_tuser,   // [0] frame_end
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_data
);

   // configuration
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [DIM_W-1:0] width_eff, height_eff;

   // position counters
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             last_col, last_row, interior;

   // line stores
   pixel_type upper_mem [MAX_WIDTH];
   pixel_type middle_mem [MAX_WIDTH];
   pixel_type upper_rd_ff, middle_rd_ff;

   // stage 1
   logic             s1_valid_ff, s1_valid_in;
   pixel_type        s1_pixel_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic             s1_interior_ff, s1_last_col_ff, s1_last_row_ff;
   logic             s1_advance;

   // window: [0],[1] top cols c-2,c-1; [2],[3] middle; [4],[5] bottom
   pixel_type win_ff [6];

   // filter
   logic [9:0]        gx_pos, gx_neg, gy_pos, gy_neg;
   logic signed [10:0] gx, gy;
   logic [9:0]        gx_abs, gy_abs;
   logic [10:0]       mag_sum;
   pixel_type         mag;

   // result register
   logic      out_valid_ff, out_valid_in;
   pixel_type out_mag_ff;
   logic      out_row_end_ff, out_frame_end_ff;

   logic      req_accept;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  width_in  = csr_data;
            CSR_FRAME_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      width_eff = width_ff;
      if (width_ff < DIM_MIN) width_eff = DIM_MIN;
      else if (width_ff > WIDTH_MAX) width_eff = WIDTH_MAX;
      height_eff = (height_ff < DIM_MIN) ? DIM_MIN : height_ff;
   end

   // ---------------- stage 0: position ----------------
   assign s1_advance = s1_valid_ff
                       & (~s1_interior_ff | ~out_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | s1_advance;
   assign req_accept = req_tvalid & req_tready;

   assign last_col = ({1'b0, col_ff} + 12'd1) >= width_eff;
   assign last_row = ({1'b0, row_ff} + 13'd1) >= {1'b0, height_eff};
   assign interior = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) s1_valid_in = 1'b1;
      else if (s1_advance) s1_valid_in = 1'b0;
   end

   // read on accept; write back when the same pixel leaves stage 1
   always_ff @(posedge clock) begin
      if (req_accept) begin
         upper_rd_ff  <= upper_mem[col_ff];
         middle_rd_ff <= middle_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         upper_mem[s1_col_ff]  <= middle_rd_ff;
         middle_mem[s1_col_ff] <= s1_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff    <= req_tdata;
         s1_col_ff      <= col_ff;
         s1_interior_ff <= interior;
         s1_last_col_ff <= last_col;
         s1_last_row_ff <= last_row;
      end
   end

   // ---------------- stage 1: filter ----------------
   assign gx_pos = {2'b0, upper_rd_ff} + {1'b0, middle_rd_ff, 1'b0} + {2'b0, s1_pixel_ff};
   assign gx_neg = {2'b0, win_ff[0]} + {1'b0, win_ff[2], 1'b0} + {2'b0, win_ff[4]};
   assign gy_pos = {2'b0, win_ff[0]} + {1'b0, win_ff[1], 1'b0} + {2'b0, upper_rd_ff};
   assign gy_neg = {2'b0, win_ff[4]} + {1'b0, win_ff[5], 1'b0} + {2'b0, s1_pixel_ff};

   assign gx = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
   assign gy = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});

   assign gx_abs  = gx[10] ? 10'(-gx) : gx[9:0];
   assign gy_abs  = gy[10] ? 10'(-gy) : gy[9:0];
   assign mag_sum = {1'b0, gx_abs} + {1'b0, gy_abs};
   assign mag     = (|mag_sum[10:8]) ? 8'hFF : mag_sum[7:0];

   // ---------------- stage 2: result register ----------------
   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_advance && s1_interior_ff) out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_interior_ff) begin
         out_mag_ff       <= mag;
         out_row_end_ff   <= s1_last_col_ff;
         out_frame_end_ff <= s1_last_col_ff & s1_last_row_ff;
      end
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         // shift the window once per pixel
         if (s1_advance) begin
            win_ff[0] <= win_ff[1];
            win_ff[1] <= upper_rd_ff;
            win_ff[2] <= win_ff[3];
            win_ff[3] <= middle_rd_ff;
            win_ff[4] <= win_ff[5];
            win_ff[5] <= s1_pixel_ff;
         end
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_mag_ff;
   assign rsp_tlast    = out_row_end_ff;
   assign rsp_tuser[0] = out_frame_end_ff;

endmodule

/* rtl/sem_checker.sv */
// ---------------------------------------------------------------------------
// sem_checker: port-level checks for the Sobel edge magnitude block
// Watches reset, result flags, stall behavior and input backpressure.
// ---------------------------------------------------------------------------
module sem_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [0:0] rsp_tuser
);

   // no result beat right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // frame end only on the last beat of a row
   a_frame_in_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("frame_end without row_end");

   // an empty result register never blocks the input
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (.*);

/* bench/sobel_edge_magnitude_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sobel_edge_magnitude_tb: self-checking regression for the Sobel edge block
// Streams greyscale frames of many sizes through the block while the sender
// idles in bursts and the receiver stalls on patterns of its own. A behavioral
// Sobel predictor follows every accepted pixel and register write, and each
// result beat is checked for magnitude, row end and frame end. Registers are
// rewritten between phases, also in the middle of a frame.
// ---------------------------------------------------------------------------
module sobel_edge_magnitude_tb;
   import sem_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_PIXELS = 1150;
   localparam int DRAIN_CYCLES  = 8;
   localparam int PRINT_CAP     = 40;

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;
   localparam logic [DIM_W-1:0]     DIM_ALL_ONES = '1;
   // columns reached later stay well below this
   localparam logic [DIM_W-1:0]     FILL_WIDTH   = 12'd128;

   // three 3x3 frames, first pixel in the top byte: vertical edge,
   // horizontal edge, single nonzero corner
   localparam logic [27*8-1:0] DIRECTED_PIXELS = {
      8'h00, 8'h00, 8'hFF,  8'h00, 8'h00, 8'hFF,  8'h00, 8'h00, 8'hFF,
      8'hFF, 8'hFF, 8'hFF,  8'h00, 8'h80, 8'h00,  8'h00, 8'h00, 8'h00,
      8'h01, 8'h00, 8'h00,  8'h00, 8'h00, 8'h00,  8'h00, 8'h00, 8'h00
   };

   typedef struct packed {
      logic [7:0] magnitude;
      logic       row_end;
      logic       frame_end;
   } edge_beat_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [DIM_W-1:0]     value;
   } reg_write_type;

   typedef enum int {TEX_NOISE, TEX_BINARY, TEX_RAMP, TEX_FLAT} texture_type;
   typedef enum int {STALL_NONE, STALL_COIN, STALL_PATTERN, STALL_HEAVY} stall_type;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata  = '0;   // [7:0] pixel
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;         // [7:0] edge_magnitude
   logic                 rsp_tlast;         // row_end
   logic [0:0]           rsp_tuser;         // [0] frame_end
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [DIM_W-1:0]     csr_data   = '0;

   logic [7:0]    pixels_pending [$];
   reg_write_type writes_pending [$];
   edge_beat_type edges_due [$];

   bit hold_sender = 1'b0;
   int mismatches  = 0;
   int cycles      = 0;
   int beats_seen  = 0;

   // predictor state
   logic [7:0]       upper_row [MAX_WIDTH];
   logic [7:0]       middle_row [MAX_WIDTH];
   logic [7:0]       window_px [6];
   logic [COL_W-1:0] col_pos;
   logic [ROW_W-1:0] row_pos;
   logic [DIM_W-1:0] width_setting;
   logic [DIM_W-1:0] height_setting;

   sobel_edge_magnitude dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("sobel_edge_magnitude regression: fail");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("%0t: mismatch at result beat %0d: %s", $time, beats_seen, what);
   endtask

   // Advance the filter by one pixel and queue the beat it produces, if any.
   function automatic void predict_edge(input logic [7:0] px);
      int w, h, c, r, tl, tc, tr, ml, mr, bl, bc, br, gx, gy, mag;
      logic [7:0] top_new, mid_new;
      bit last_col, last_row;
      edge_beat_type beat;
      w = int'(width_setting);
      h = int'(height_setting);
      if (w < int'(DIM_MIN)) w = int'(DIM_MIN);
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h < int'(DIM_MIN)) h = int'(DIM_MIN);
      c = int'(col_pos);
      r = int'(row_pos);
      top_new = upper_row[c];
      mid_new = middle_row[c];
      upper_row[c]  = mid_new;
      middle_row[c] = px;
      last_col = (c + 1 >= w);
      last_row = (r + 1 >= h);
      if (r >= 2 && c >= 2) begin
         tl = window_px[0]; tc = window_px[1]; tr = top_new;
         ml = window_px[2]; mr = mid_new;
         bl = window_px[4]; bc = window_px[5]; br = px;
         gx = (tr + 2 * mr + br) - (tl + 2 * ml + bl);
         gy = (tl + 2 * tc + tr) - (bl + 2 * bc + br);
         mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
         beat.magnitude = (mag > 255) ? 8'hFF : mag[7:0];
         beat.row_end   = last_col;
         beat.frame_end = last_col && last_row;
         edges_due.push_back(beat);
      end
      window_px[0] = window_px[1]; window_px[1] = top_new;
      window_px[2] = window_px[3]; window_px[3] = mid_new;
      window_px[4] = window_px[5]; window_px[5] = px;
      if (last_col) begin
         col_pos = '0;
         row_pos = last_row ? '0 : ROW_W'(r + 1);
      end else begin
         col_pos = COL_W'(c + 1);
      end
   endfunction

   function automatic logic [7:0] make_pixel(input texture_type tex, input int x, input int y);
      case (tex)
         TEX_NOISE:  return 8'($urandom);
         TEX_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         TEX_RAMP:   return 8'(x * 37 + y * 11);
         default:    return 8'(125 + $urandom_range(0, 6));
      endcase
   endfunction

   // pixel sender: bursts of random length with random gaps
   int gap_left   = 0;
   int burst_left = 1;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   = 0;
         burst_left = 1;
      end else begin
         if (req_tvalid && req_tready)
            void'(pixels_pending.pop_front());
         if (req_tvalid && !req_tready) begin
            // hold the beat until taken
         end else if (gap_left > 0 || hold_sender || pixels_pending.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= pixels_pending[0];
            burst_left--;
            if (burst_left <= 0) begin
               if ($urandom_range(0, 3) == 0) begin
                  burst_left = $urandom_range(50, 300);
                  gap_left   = 0;
               end else begin
                  burst_left = $urandom_range(1, 30);
                  gap_left   = $urandom_range(1, 12);
               end
            end
         end
      end
   end

   // register write channel
   always @(posedge clock) begin
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready)
            void'(writes_pending.pop_front());
         if (!(csr_valid && !csr_ready)) begin
            if (writes_pending.size() != 0) begin
               csr_valid <= 1'b1;
               csr_index <= writes_pending[0].index;
               csr_data  <= writes_pending[0].value;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   // result receiver: switch stall style every so often
   stall_type   stall_mode = STALL_NONE;
   int          mode_left  = 0;
   logic [7:0]  ready_pattern = 8'hFF;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         mode_left  = 0;
      end else begin
         if (mode_left == 0) begin
            stall_mode    = stall_type'($urandom_range(0, 3));
            mode_left     = $urandom_range(20, 300);
            ready_pattern = 8'($urandom);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            STALL_NONE: rsp_tready <= 1'b1;
            STALL_COIN: rsp_tready <= 1'($urandom_range(0, 1));
            STALL_PATTERN: begin
               rsp_tready    <= ready_pattern[0];
               ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
            end
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // monitor: check result beats, track register writes, predict per pixel
   always @(posedge clock) begin : monitor
      edge_beat_type due;
      if (reset) begin
         for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
         end
         for (int i = 0; i < 6; i++) window_px[i] = '0;
         col_pos        = '0;
         row_pos        = '0;
         width_setting  = WIDTH_RESET;
         height_setting = HEIGHT_RESET;
         edges_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (edges_due.size() == 0) begin
               report_mismatch("result beat with no pixel calling for it");
            end else begin
               due = edges_due.pop_front();
               if (rsp_tdata !== due.magnitude)
                  report_mismatch($sformatf("magnitude %0d, expected %0d",
                                            rsp_tdata, due.magnitude));
               if (rsp_tlast !== due.row_end)
                  report_mismatch($sformatf("row end %b, expected %b",
                                            rsp_tlast, due.row_end));
               if (rsp_tuser[0] !== due.frame_end)
                  report_mismatch($sformatf("frame end %b, expected %b",
                                            rsp_tuser[0], due.frame_end));
            end
            beats_seen++;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  width_setting  = csr_data;
               CSR_FRAME_HEIGHT: height_setting = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_edge(req_tdata);
      end
   end

   // wait until the block has drained, then give a border pixel time to leave
   task automatic settle();
      do @(negedge clock);
      while (pixels_pending.size() != 0 || req_tvalid || edges_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_reg(input logic [CSR_IDX_W-1:0] index, input logic [DIM_W-1:0] value);
      reg_write_type wr;
      wr.index = index;
      wr.value = value;
      writes_pending.push_back(wr);
      do @(negedge clock);
      while (writes_pending.size() != 0 || csr_valid);
   endtask

   initial begin : stimulus
      int eff_w, eff_h, count, random_sent, phase;
      logic [DIM_W-1:0] value;
      texture_type tex;
      bit last_mid;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sizes below the floor clamp to 3x3
      set_reg(CSR_FRAME_WIDTH, 12'd1);
      set_reg(CSR_FRAME_HEIGHT, '0);
      for (int i = 0; i < 27; i++)
         pixels_pending.push_back(DIRECTED_PIXELS[(26 - i) * 8 +: 8]);
      settle();

      // one wide frame fills every line store entry that later frames reach
      set_reg(CSR_FRAME_WIDTH, FILL_WIDTH);
      set_reg(CSR_FRAME_HEIGHT, DIM_MIN);
      for (int i = 0; i < 3 * int'(FILL_WIDTH); i++)
         pixels_pending.push_back(make_pixel(TEX_NOISE, i, 0));
      settle();

      set_reg(CSR_SPARE_LO, DIM_ALL_ONES);
      set_reg(CSR_SPARE_HI, DIM_ALL_ONES);

      random_sent = 0;
      phase = 0;
      last_mid = 1'b0;
      while (random_sent < RANDOM_PIXELS) begin
         tex = texture_type'($urandom_range(0, 3));
         // never two changes in the middle of a frame in a row, so the
         // column stays inside the filled part of the line stores
         if (last_mid || $urandom_range(0, 3) != 0) begin
            last_mid = 1'b0;
            // whole frames at a fresh size
            set_reg(CSR_FRAME_WIDTH, ($urandom_range(0, 9) == 0) ?
                    DIM_W'($urandom_range(0, 2)) : DIM_W'($urandom_range(3, 24)));
            set_reg(CSR_FRAME_HEIGHT, ($urandom_range(0, 9) == 0) ?
                    DIM_W'($urandom_range(0, 2)) : DIM_W'($urandom_range(3, 7)));
            eff_w = (width_setting < DIM_MIN) ? int'(DIM_MIN) : int'(width_setting);
            eff_h = (height_setting < DIM_MIN) ? int'(DIM_MIN) : int'(height_setting);
            count = eff_w * eff_h * int'($urandom_range(1, 2));
         end else begin
            last_mid = 1'b1;
            // change one register in the middle of a frame
            if ($urandom_range(0, 1) == 0) begin
               case ($urandom_range(0, 3))
                  0:       value = DIM_W'($urandom_range(WIDTH_MAX, DIM_ALL_ONES));
                  1:       value = DIM_W'($urandom_range(0, 2));
                  default: value = DIM_W'($urandom_range(3, 40));
               endcase
               set_reg(CSR_FRAME_WIDTH, value);
            end else begin
               case ($urandom_range(0, 3))
                  0:       value = DIM_ALL_ONES;
                  1:       value = DIM_W'($urandom_range(0, 2));
                  default: value = DIM_W'($urandom_range(3, 10));
               endcase
               set_reg(CSR_FRAME_HEIGHT, value);
            end
            eff_w = 17;
            count = int'($urandom_range(1, 60));
         end
         for (int i = 0; i < count; i++)
            pixels_pending.push_back(make_pixel(tex, i % eff_w, i / eff_w));
         random_sent += count;

         if (phase == 0 || $urandom_range(0, 9) == 0) begin
            // hold new pixels back until every owed result is out
            do @(negedge clock);
            while (pixels_pending.size() > count / 2);
            hold_sender = 1'b1;
            do @(negedge clock);
            while (req_tvalid || edges_due.size() != 0);
            hold_sender = 1'b0;
         end
         settle();
         phase++;
      end

      if (mismatches == 0)
         $display("sobel_edge_magnitude regression: pass");
      else
         $display("sobel_edge_magnitude regression: fail");
      $finish;
   end

endmodule

/* sobel_edge_magnitude.f */
rtl/sem_pkg.sv
rtl/sobel_edge_magnitude.sv
rtl/sem_checker.sv
bench/sobel_edge_magnitude_tb.sv
